// ===== hdl/kss_pkg.sv =====
// ----------------------------------------------------------------------------
// kss_pkg
// Shared constants, types and state encoding for the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int VALUE_W      = 32;
    localparam int K_W          = 4;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    // wide enough for window_k + 1 and for the depth itself
    localparam int CAP_W        = (CNT_W > K_W + 1) ? CNT_W : K_W + 1;

    typedef logic signed [VALUE_W-1:0] t_value;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_value value;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_INS,
        S_DRAIN
    } t_state;

endpackage

// ===== hdl/kss_cell.sv =====
// ----------------------------------------------------------------------------
// kss_cell
// One slot of the sorted chain: holds one value, shifts right on insert
// past it, shifts left on pop.
// ----------------------------------------------------------------------------
module kss_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kss_pkg::t_cell_cmd i_cmd,
    input  kss_pkg::t_value    i_left_val,
    input  logic               i_left_vld,
    input  logic               i_left_cmp,
    input  kss_pkg::t_value    i_right_val,
    input  logic               i_right_vld,
    output kss_pkg::t_value    o_val,
    output logic               o_vld,
    output logic               o_cmp
);

    kss_pkg::t_value r_val, n_val;
    logic            r_vld, n_vld;

    // held value is no larger than the incoming one: it stays put
    assign o_cmp = r_vld && (r_val <= i_cmd.value);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_cmd.pop) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_cmd.ins && !o_cmp) begin
            n_val = i_left_cmp ? i_cmd.value : i_left_val;
            n_vld = r_vld | i_left_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

// ===== hdl/kss_chain.sv =====
// ----------------------------------------------------------------------------
// kss_chain
// Row of cells kept in ascending order; the head cell holds the minimum.
// ----------------------------------------------------------------------------
module kss_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kss_pkg::t_cell_cmd i_cmd,
    output kss_pkg::t_value    o_head_val
);

    localparam int N = kss_pkg::WINDOW_DEPTH;

    kss_pkg::t_value w_val [N];
    logic            w_vld [N];
    logic            w_cmp [N];

    for (genvar i = 0; i < N; i++) begin : g_cell
        kss_pkg::t_value w_lval, w_rval;
        logic            w_lvld, w_lcmp, w_rvld;

        if (i == 0) begin : g_head
            assign w_lval = '0;
            assign w_lvld = 1'b1;
            assign w_lcmp = 1'b1;
        end else begin : g_mid
            assign w_lval = w_val[i-1];
            assign w_lvld = w_vld[i-1];
            assign w_lcmp = w_cmp[i-1];
        end

        if (i == N - 1) begin : g_tail
            assign w_rval = '0;
            assign w_rvld = 1'b0;
        end else begin : g_next
            assign w_rval = w_val[i+1];
            assign w_rvld = w_vld[i+1];
        end

        kss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_left_val  (w_lval),
            .i_left_vld  (w_lvld),
            .i_left_cmp  (w_lcmp),
            .i_right_val (w_rval),
            .i_right_vld (w_rvld),
            .o_val       (w_val[i]),
            .o_vld       (w_vld[i]),
            .o_cmp       (w_cmp[i])
        );
    end

    assign o_head_val = w_val[0];

endmodule

// ===== hdl/k_sorted_stream_sorter.sv =====
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a nearly sorted stream through a window of window_k+1 values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_value and i_last.
//   Output channel (o_out_valid / i_out_stall) carries o_sorted_value,
//   o_run_end and o_sequence_end. An item moves when valid is high and
//   stall is low.
//   Config channel (i_cfg_valid / o_cfg_ready) writes window_k; write it
//   only while the block is idle. o_cfg_ready is always high.
//   An item that only fills the window is inserted into the sorted cell
//   row; one that finds the window full first pops the head cell, then is
//   inserted. The input stays stalled until the item is through. A last
//   item is followed by a drain of the held values, one result per cycle
//   while the output register can take it. A popped minimum is registered
//   into the output register in the pop step that follows the accepted item.
//   Results wait in one output register; while the receiver stalls, the
//   pop or drain step waits and o_in_stall stays high.
//   Reset clears the window, the count, window_k and the output valid.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  kss_pkg::t_value             i_value,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output kss_pkg::t_value             o_sorted_value,
    output logic                        o_run_end,
    output logic                        o_sequence_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [kss_pkg::K_W-1:0]     i_cfg_window_k
);

    localparam int CNT_W = kss_pkg::CNT_W;
    localparam int CAP_W = kss_pkg::CAP_W;
    localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(kss_pkg::WINDOW_DEPTH);

    kss_pkg::t_state    r_state, n_state;
    logic [kss_pkg::K_W-1:0] r_k;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    kss_pkg::t_value    r_in_val;
    logic               r_in_last;
    logic               r_out_vld, n_out_vld;
    kss_pkg::t_value    r_out_val;
    logic               r_out_run, r_out_seq;

    kss_pkg::t_cell_cmd w_cmd;
    kss_pkg::t_value    w_head;
    logic               w_accept, w_slot, w_full, w_emit, w_fin;
    logic [CAP_W-1:0]   w_cap_raw, w_cap;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_slot    = !r_out_vld || !i_out_stall;
    assign w_cap_raw = CAP_W'(r_k) + CAP_W'(1);
    assign w_cap     = (w_cap_raw > DEPTH_C) ? DEPTH_C : w_cap_raw;
    assign w_full    = (CAP_W'(r_cnt) >= w_cap) && (r_cnt != '0);
    assign w_fin     = (r_cnt == CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kss_pkg::S_IDLE: begin
                if (w_accept) n_state = w_full ? kss_pkg::S_POP : kss_pkg::S_INS;
            end
            kss_pkg::S_POP: begin
                if (w_slot) n_state = kss_pkg::S_INS;
            end
            kss_pkg::S_INS: begin
                n_state = r_in_last ? kss_pkg::S_DRAIN : kss_pkg::S_IDLE;
            end
            kss_pkg::S_DRAIN: begin
                if (w_slot && w_fin) n_state = kss_pkg::S_IDLE;
            end
            default: n_state = kss_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall  = 1'b1;
        w_cmd.ins   = 1'b0;
        w_cmd.pop   = 1'b0;
        w_cmd.value = r_in_val;
        w_emit      = 1'b0;
        case (r_state)
            kss_pkg::S_IDLE:  o_in_stall = 1'b0;
            kss_pkg::S_POP:   w_emit     = w_slot;
            kss_pkg::S_INS:   w_cmd.ins  = 1'b1;
            kss_pkg::S_DRAIN: w_emit     = w_slot;
            default:          o_in_stall = 1'b1;
        endcase
        w_cmd.pop = w_emit;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_cmd.ins) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_emit) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
        n_out_vld = r_out_vld && i_out_stall;
        if (w_emit) n_out_vld = 1'b1;
    end

    kss_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_head_val (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_val  <= i_value;
            r_in_last <= i_last;
        end
        if (w_emit) begin
            r_out_val <= w_head;
            if (r_state == kss_pkg::S_POP) begin
                r_out_run <= !r_in_last;
                r_out_seq <= 1'b0;
            end else begin
                r_out_run <= w_fin;
                r_out_seq <= w_fin;
            end
        end
        if (!i_rst_n) begin
            r_state   <= kss_pkg::S_IDLE;
            r_cnt     <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) r_k <= i_cfg_window_k;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_run_end      = r_out_run;
    assign o_sequence_end = r_out_seq;

endmodule

// ===== hdl/kss_checker.sv =====
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks on the sorter, bound to the top level.
// ----------------------------------------------------------------------------
module kss_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input kss_pkg::t_value o_sorted_value,
    input logic            o_run_end,
    input logic            o_sequence_end
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sorted_value) && $stable(o_run_end)
            && $stable(o_sequence_end))
        else $error("stalled result changed");

    // end of sequence is always also the end of its run
    a_seq_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sequence_end |-> o_run_end)
        else $error("sequence_end without run_end");

    // an accepted item keeps the input stalled in the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind k_sorted_stream_sorter kss_checker u_kss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sorted_value (o_sorted_value),
    .o_run_end      (o_run_end),
    .o_sequence_end (o_sequence_end)
);
